### hdl/lzw_pkg.sv
// Shared constants and controller/datapath interface types for the LZW compressor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzw_pkg;
    localparam int CODE_BITS_DEF = 12;
    localparam int BASE_CODES    = 256;
    localparam int EPOCH_BITS    = 8;

    typedef struct packed {
        logic accept;
        logic probe_next;
        logic take_hit;
        logic insert_miss;
        logic emit_miss;
        logic emit_flush;
        logic clr_step;
        logic clr_finish;
    } lzw_cmd_t;

    typedef struct packed {
        logic active;
        logic last;
        logic hit;
        logic occupied;
        logic out_free;
        logic clr_done;
        logic epoch_wrap;
    } lzw_sts_t;
endpackage
`default_nettype wire

### hdl/lzw_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hdl/lzw_ctrl.sv
// Controller state machine of the LZW compressor: sequences clear, probe, insert, emit.
// Depends on lzw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzw_ctrl
    import lzw_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_tlast,
    output logic          s_tready,
    input  wire lzw_sts_t sts,
    output lzw_cmd_t      cmd
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PROBE = 3'd2;
    localparam logic [2:0] ST_CHECK = 3'd3;
    localparam logic [2:0] ST_MISS  = 3'd4;
    localparam logic [2:0] ST_FLUSH = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done) begin
                    cmd.clr_finish = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.active) begin
                        state_next = ST_PROBE;
                    end else if (s_tlast) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_PROBE: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = sts.last ? ST_FLUSH : ST_IDLE;
                end else if (sts.occupied) begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_PROBE;
                end else begin
                    cmd.insert_miss = 1'b1;
                    state_next      = ST_MISS;
                end
            end
            ST_MISS: begin
                if (sts.out_free) begin
                    cmd.emit_miss = 1'b1;
                    state_next    = sts.last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.emit_flush = 1'b1;
                    // epoch wrap needs a fresh clear of the table
                    state_next     = sts.epoch_wrap ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end
endmodule
`default_nettype wire

### hdl/lzw_dp.sv
// Datapath of the LZW compressor: phrase state, hashed pair table, output register.
// Depends on lzw_pkg and lzw_ram.
`timescale 1ns / 1ps
`default_nettype none
module lzw_dp
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF,
    localparam int TB = CODE_BITS + 1,
    localparam int OW = ((CODE_BITS + 7) / 8) * 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [7:0]    s_tdata,
    input  wire logic          s_tlast,
    input  wire logic          s_tvalid,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [OW-1:0] m_tdata,
    output logic               m_tlast,
    input  wire lzw_cmd_t      cmd,
    output lzw_sts_t           sts
);
    localparam int EW = EPOCH_BITS + CODE_BITS + 8 + CODE_BITS;
    localparam logic [CODE_BITS:0] LIMIT = (CODE_BITS + 1)'(1) << CODE_BITS;

    logic [7:0]            byte_reg;
    logic                  last_reg;
    logic [CODE_BITS-1:0]  cur_reg;
    logic                  active_reg;
    logic [CODE_BITS:0]    nfree_reg;
    logic [EPOCH_BITS-1:0] epoch_reg;
    logic [TB-1:0]         paddr_reg;
    logic [TB-1:0]         clr_reg;
    logic                  mv_reg;
    logic [CODE_BITS-1:0]  mcode_reg;
    logic                  mlast_reg;

    logic                  we;
    logic [TB-1:0]         waddr;
    logic [EW-1:0]         wdata;
    logic [EW-1:0]         rdata;
    logic [EPOCH_BITS-1:0] r_tag;
    logic [CODE_BITS-1:0]  r_pre;
    logic [7:0]            r_sfx;
    logic [CODE_BITS-1:0]  r_code;
    logic                  can_ins;
    logic [TB-1:0]         hash;

    assign {r_tag, r_pre, r_sfx, r_code} = rdata;
    assign hash    = {cur_reg, 1'b0} ^ {s_tdata, {(TB-8){1'b0}}};
    assign can_ins = nfree_reg < LIMIT;
    assign we      = cmd.clr_step || (cmd.insert_miss && can_ins);
    assign waddr   = cmd.clr_step ? clr_reg : paddr_reg;
    assign wdata   = cmd.clr_step ? '0 :
                     {epoch_reg, cur_reg, byte_reg, nfree_reg[CODE_BITS-1:0]};

    lzw_ram #(.WIDTH(EW), .DEPTH(1 << TB)) u_tbl (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(paddr_reg),
        .rdata(rdata)
    );

    assign sts.active     = active_reg;
    assign sts.last       = last_reg;
    assign sts.occupied   = r_tag == epoch_reg;
    assign sts.hit        = sts.occupied && r_pre == cur_reg && r_sfx == byte_reg;
    assign sts.out_free   = !mv_reg || m_tready;
    assign sts.clr_done   = &clr_reg;
    assign sts.epoch_wrap = &epoch_reg;

    assign m_tvalid = mv_reg;
    assign m_tdata  = OW'(mcode_reg);
    assign m_tlast  = mlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            cur_reg    <= '0;
            nfree_reg  <= (CODE_BITS + 1)'(BASE_CODES);
            epoch_reg  <= '0;
            clr_reg    <= '0;
            mv_reg     <= 1'b0;
        end else begin
            if (cmd.emit_miss || cmd.emit_flush) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (cmd.clr_step) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.clr_finish) begin
                epoch_reg <= EPOCH_BITS'(1);
            end
            if (cmd.accept && s_tvalid) begin
                byte_reg  <= s_tdata;
                last_reg  <= s_tlast;
                paddr_reg <= hash;
                if (!active_reg) begin
                    cur_reg    <= CODE_BITS'(s_tdata);
                    active_reg <= 1'b1;
                end
            end
            if (cmd.probe_next) begin
                paddr_reg <= paddr_reg + 1'b1;
            end
            if (cmd.take_hit) begin
                cur_reg <= r_code;
            end
            if (cmd.insert_miss && can_ins) begin
                nfree_reg <= nfree_reg + 1'b1;
            end
            if (cmd.emit_miss) begin
                mcode_reg <= cur_reg;
                mlast_reg <= 1'b0;
                cur_reg   <= CODE_BITS'(byte_reg);
            end
            if (cmd.emit_flush) begin
                mcode_reg  <= cur_reg;
                mlast_reg  <= 1'b1;
                active_reg <= 1'b0;
                cur_reg    <= '0;
                nfree_reg  <= (CODE_BITS + 1)'(BASE_CODES);
                epoch_reg  <= epoch_reg + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### hdl/lzw_compressor.sv
// Top level of the LZW compressor: controller, datapath and hashed pair table.
// Depends on lzw_pkg, lzw_ctrl, lzw_dp, lzw_ram.
`timescale 1ns / 1ps
`default_nettype none
// LZW compressor, one byte per request on the s_ side, codes of CODE_BITS bits on the m_ side;
// s_tlast marks the last byte of a message and m_tlast the flushed last code. Each message starts
// with an empty dictionary. A byte whose first hash probe hits passes through probe and check;
// a miss then also inserts the pair and emits a code, and each extra linear probe of the pair
// table repeats probe and check (table has 2^(CODE_BITS+1) slots, so probes stay short).
// The first byte of a message only loads the phrase, and the last byte adds a flush of the
// final code. Waiting for m_tready while a code is held stalls these steps. After reset, and
// after every 255 messages, a clearing pass over every table slot runs with s_tready low.
module lzw_compressor
    import lzw_pkg::*;
#(
    parameter int CODE_BITS = CODE_BITS_DEF,
    localparam int OW = ((CODE_BITS + 7) / 8) * 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // data_byte
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [OW-1:0] m_tdata,   // code_word, zero filled
    output logic               m_tlast
);
    lzw_cmd_t cmd;
    lzw_sts_t sts;

    lzw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tlast (s_tlast),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lzw_dp #(.CODE_BITS(CODE_BITS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .cmd     (cmd),
        .sts     (sts)
    );
endmodule
`default_nettype wire
